>>> src/lavm_pkg.sv
// Shared types, constants and arithmetic helpers of the look-at view matrix block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lavm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int DDW       = DW + 1;
	// Vector magnitudes: the cross product of up and forward reaches 2^(DW+FRAC_BITS).
	localparam int MW        = FRAC_BITS + DW + 1;
	localparam int AW        = 64;
	localparam int VW        = FRAC_BITS + 2;
	localparam int UW        = FRAC_BITS + 3;
	localparam int LW        = 32;
	localparam int NORM_HI   = 30;
	localparam int NORM_LO   = 29;
	localparam int QW        = FRAC_BITS + 2;
	localparam int NUMW      = FRAC_BITS + NORM_HI + 1;
	localparam int DCW       = $clog2(QW);
	localparam int JOB_DEPTH = 2;
	localparam int PTRW      = $clog2(JOB_DEPTH);

	localparam logic signed [DW-1:0] ONE_FX = DW'(64'd1 << FRAC_BITS);
	localparam logic signed [AW-1:0] SAT_HI = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(64'sd1);

	typedef struct packed {
		logic [2:0][DW-1:0]  eye;
		logic [2:0][DW-1:0]  up;
		logic [2:0][DDW-1:0] dir;
		logic                fwd_zero;
	} lavm_job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DIVI,
		ST_DIV,
		ST_CROSS,
		ST_UP,
		ST_UFIN,
		ST_DOT,
		ST_TFIN,
		ST_EMIT
	} lavm_state_t;

	// Shift right by FRAC_BITS, rounding half away from zero.
	function automatic logic signed [AW-1:0] shr_round(input logic signed [AW-1:0] x);
		logic [AW-1:0] m;
		m = x[AW-1] ? unsigned'(-x) : unsigned'(x);
		m = (m + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return x[AW-1] ? -signed'(m) : signed'(m);
	endfunction

	function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] x);
		if (x > SAT_HI) begin
			return SAT_HI[DW-1:0];
		end else if (x < SAT_LO) begin
			return SAT_LO[DW-1:0];
		end
		return x[DW-1:0];
	endfunction

endpackage

>>> src/lavm_in_if.sv
// Input channel of the look-at view matrix block: eye, target and up vector.
// Depends on lavm_pkg for the field width.
interface lavm_in_if;
	logic                          valid;
	logic                          ready;
	logic signed [lavm_pkg::DW-1:0] eye_x;
	logic signed [lavm_pkg::DW-1:0] eye_y;
	logic signed [lavm_pkg::DW-1:0] eye_z;
	logic signed [lavm_pkg::DW-1:0] look_x;
	logic signed [lavm_pkg::DW-1:0] look_y;
	logic signed [lavm_pkg::DW-1:0] look_z;
	logic signed [lavm_pkg::DW-1:0] up_x;
	logic signed [lavm_pkg::DW-1:0] up_y;
	logic signed [lavm_pkg::DW-1:0] up_z;

	modport source(output valid, eye_x, eye_y, eye_z, look_x, look_y, look_z,
		up_x, up_y, up_z, input ready);
	modport sink(input valid, eye_x, eye_y, eye_z, look_x, look_y, look_z,
		up_x, up_y, up_z, output ready);
endinterface

>>> src/lavm_out_if.sv
// Output channel of the look-at view matrix block: one matrix row per item.
// Depends on lavm_pkg for the field width.
interface lavm_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    row_index;
	logic signed [lavm_pkg::DW-1:0] col_0;
	logic signed [lavm_pkg::DW-1:0] col_1;
	logic signed [lavm_pkg::DW-1:0] col_2;
	logic signed [lavm_pkg::DW-1:0] col_3;
	logic                          last_row;
	logic                          degenerate;

	modport source(output valid, row_index, col_0, col_1, col_2, col_3, last_row,
		degenerate, input ready);
	modport sink(input valid, row_index, col_0, col_1, col_2, col_3, last_row,
		degenerate, output ready);
endinterface

>>> src/lavm_front.sv
// Front end: accepts input items, forms the view direction and queues the jobs.
// Depends on lavm_pkg and lavm_in_if.
module lavm_front (
	input  logic                clk,
	input  logic                arst_n,
	lavm_in_if.sink             pts,
	output lavm_pkg::lavm_job_t job,
	output logic                job_valid,
	input  logic                job_pop
);

	lavm_pkg::lavm_job_t             entry;
	lavm_pkg::lavm_job_t             fifo_q [lavm_pkg::JOB_DEPTH];
	logic [lavm_pkg::PTRW-1:0]       wr_ptr_q;
	logic [lavm_pkg::PTRW-1:0]       rd_ptr_q;
	logic [lavm_pkg::PTRW:0]         count_q;
	logic                            push;
	logic                            pop;

	always_comb begin
		entry.eye = {pts.eye_z, pts.eye_y, pts.eye_x};
		entry.up  = {pts.up_z, pts.up_y, pts.up_x};
		entry.dir[0] = lavm_pkg::DDW'(pts.look_x) - lavm_pkg::DDW'(pts.eye_x);
		entry.dir[1] = lavm_pkg::DDW'(pts.look_y) - lavm_pkg::DDW'(pts.eye_y);
		entry.dir[2] = lavm_pkg::DDW'(pts.look_z) - lavm_pkg::DDW'(pts.eye_z);
		entry.fwd_zero = (pts.look_x == pts.eye_x) && (pts.look_y == pts.eye_y)
			&& (pts.look_z == pts.eye_z);
	end

	assign pts.ready = (count_q != (lavm_pkg::PTRW+1)'(lavm_pkg::JOB_DEPTH));
	assign push      = pts.valid && pts.ready;
	assign job_valid = (count_q != '0);
	assign pop       = job_pop && job_valid;
	assign job       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lavm_pkg::PTRW'(lavm_pkg::JOB_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lavm_pkg::PTRW'(lavm_pkg::JOB_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (lavm_pkg::PTRW+1)'(lavm_pkg::JOB_DEPTH))
		else $error("job queue holds more entries than it has");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job taken from an empty queue");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

>>> src/lavm_back.sv
// Back end: normalizes forward and right, forms true up and the translation row,
// and emits the four rows. Depends on lavm_pkg and lavm_out_if.
module lavm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lavm_pkg::lavm_job_t job,
	input  logic                job_valid,
	output logic                job_pop,
	lavm_out_if.source          rows
);

	localparam logic [3:0] N_SQ    = 4'd3;
	localparam logic [3:0] N_CROSS = 4'd6;
	localparam logic [3:0] N_UP    = 4'd6;
	localparam logic [3:0] N_DOT   = 4'd9;

	lavm_pkg::lavm_state_t state_q, state_d;

	logic signed [lavm_pkg::DW-1:0]  eye_q [3];
	logic signed [lavm_pkg::DW-1:0]  up_q  [3];
	logic [lavm_pkg::MW-1:0]         mag_q [3];
	logic                            neg_q [3];
	logic signed [lavm_pkg::VW-1:0]  f_q   [3];
	logic signed [lavm_pkg::VW-1:0]  r_q   [3];
	logic signed [lavm_pkg::UW-1:0]  u_q   [3];
	logic signed [lavm_pkg::DW-1:0]  t_q   [3];
	logic                            pass_q;
	logic                            degen_q;
	logic [3:0]                      cnt_q;

	logic [lavm_pkg::AW-1:0]         x_q, sr_q, bit_q;
	logic [lavm_pkg::QW-1:0]         num_q;
	logic [lavm_pkg::LW-1:0]         rem_q;
	logic [lavm_pkg::QW-1:0]         quot_q;
	logic [lavm_pkg::DCW-1:0]        dcnt_q;
	logic [1:0]                      comp_q;

	logic signed [lavm_pkg::DW-1:0]  mac_a, mac_b;
	logic                            mac_go, mac_clr, mac_sub, mac_last;
	logic [1:0]                      mac_dst;
	logic signed [lavm_pkg::AW-1:0]  mul_p;
	logic signed [lavm_pkg::AW-1:0]  prod_s1;
	logic                            mac_vld_s1, mac_clr_s1, mac_sub_s1, mac_last_s1;
	logic [1:0]                      mac_dst_s1;
	logic signed [lavm_pkg::AW-1:0]  acc_q, acc_nx;
	logic signed [lavm_pkg::AW-1:0]  res_q [3];

	logic                            out_vld_q;
	logic [1:0]                      row_q;
	logic [1:0]                      row_out_q;
	logic signed [lavm_pkg::DW-1:0]  col_q [4];
	logic                            last_q, degen_out_q;
	logic                            out_load;

	logic [lavm_pkg::MW-1:0]         m_max;
	logic                            too_big, too_small;
	logic [lavm_pkg::AW-1:0]         sq_try;
	logic                            sq_ge;
	logic [lavm_pkg::LW-1:0]         len;
	logic [lavm_pkg::LW:0]           r2;
	logic                            d_ge;
	logic [lavm_pkg::QW-1:0]         quot_nx;
	logic signed [lavm_pkg::VW-1:0]  q_signed;
	logic [lavm_pkg::MW-1:0]         div_mag;
	logic                            div_neg;
	logic [lavm_pkg::NUMW-1:0]       num_init;
	logic signed [lavm_pkg::AW-1:0]  lv_src [3];
	logic [lavm_pkg::MW-1:0]         lv_mag [3];
	logic                            lv_neg [3];
	logic                            lv_zero;
	logic [1:0]                      mj, mj1, mj2, mk;
	logic signed [lavm_pkg::DW-1:0]  em_col [4];
	logic                            em_last;

	function automatic logic [1:0] nxt(input logic [1:0] j);
		case (j)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	// Normalization scan, square root step and division step.
	always_comb begin
		m_max = mag_q[0];
		if (mag_q[1] > m_max) m_max = mag_q[1];
		if (mag_q[2] > m_max) m_max = mag_q[2];
		too_big   = |m_max[lavm_pkg::MW-1:lavm_pkg::NORM_HI];
		too_small = ~|m_max[lavm_pkg::MW-1:lavm_pkg::NORM_LO];
		sq_try    = sr_q + bit_q;
		sq_ge     = (x_q >= sq_try);
		len       = sr_q[lavm_pkg::LW-1:0];
		r2        = {rem_q, num_q[dcnt_q]};
		d_ge      = (r2 >= {1'b0, len});
		quot_nx   = {quot_q[lavm_pkg::QW-2:0], d_ge};
		q_signed  = signed'(quot_nx);
		case (comp_q)
			2'd0:    begin div_mag = mag_q[0]; div_neg = neg_q[0]; end
			2'd1:    begin div_mag = mag_q[1]; div_neg = neg_q[1]; end
			default: begin div_mag = mag_q[2]; div_neg = neg_q[2]; end
		endcase
		num_init = {div_mag[lavm_pkg::NORM_HI-1:0], lavm_pkg::FRAC_BITS'(0)}
			+ lavm_pkg::NUMW'(len >> 1);
	end

	// Vector loader: the direction of a new job or the cross product just formed.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lv_src[i] = (state_q == lavm_pkg::ST_IDLE) ? lavm_pkg::AW'($signed(job.dir[i]))
				: res_q[i];
			lv_neg[i] = lv_src[i][lavm_pkg::AW-1];
			lv_mag[i] = lv_neg[i] ? lavm_pkg::MW'(-lv_src[i]) : lavm_pkg::MW'(lv_src[i]);
		end
		lv_zero = (res_q[0] == '0) && (res_q[1] == '0) && (res_q[2] == '0);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mac_go   = 1'b0;
		mac_a    = '0;
		mac_b    = '0;
		mac_clr  = 1'b0;
		mac_sub  = 1'b0;
		mac_last = 1'b0;
		mac_dst  = 2'd0;
		mj       = cnt_q[2:1];
		if (mj == 2'd3) mj = 2'd0;
		mj1      = nxt(mj);
		mj2      = nxt(mj1);
		if (cnt_q < 4'd3) begin
			mk = cnt_q[1:0];
			if (mk == 2'd3) mk = 2'd0;
		end else if (cnt_q < 4'd6) begin
			mk = 2'(cnt_q - 4'd3);
		end else if (cnt_q < 4'd9) begin
			mk = 2'(cnt_q - 4'd6);
		end else begin
			mk = 2'd0;
		end
		case (state_q)
			lavm_pkg::ST_SQ: begin
				mac_go   = (cnt_q < N_SQ);
				mac_a    = lavm_pkg::DW'(mag_q[mk][lavm_pkg::NORM_HI-1:0]);
				mac_b    = mac_a;
				mac_clr  = (mk == 2'd0);
				mac_last = (mk == 2'd2);
			end
			lavm_pkg::ST_CROSS, lavm_pkg::ST_UP: begin
				mac_go   = (cnt_q < N_CROSS);
				mac_sub  = cnt_q[0];
				mac_clr  = !cnt_q[0];
				mac_last = cnt_q[0];
				mac_dst  = mj;
				if (state_q == lavm_pkg::ST_CROSS) begin
					mac_a = cnt_q[0] ? up_q[mj2] : up_q[mj1];
					mac_b = cnt_q[0] ? lavm_pkg::DW'(f_q[mj1]) : lavm_pkg::DW'(f_q[mj2]);
				end else begin
					mac_a = cnt_q[0] ? lavm_pkg::DW'(f_q[mj2]) : lavm_pkg::DW'(f_q[mj1]);
					mac_b = cnt_q[0] ? lavm_pkg::DW'(r_q[mj1]) : lavm_pkg::DW'(r_q[mj2]);
				end
			end
			lavm_pkg::ST_DOT: begin
				mac_go   = (cnt_q < N_DOT);
				mac_clr  = (mk == 2'd0);
				mac_last = (mk == 2'd2);
				mac_b    = eye_q[mk];
				if (cnt_q < 4'd3) begin
					mac_dst = 2'd0;
					mac_a   = lavm_pkg::DW'(r_q[mk]);
				end else if (cnt_q < 4'd6) begin
					mac_dst = 2'd1;
					mac_a   = lavm_pkg::DW'(u_q[mk]);
				end else begin
					mac_dst = 2'd2;
					mac_a   = lavm_pkg::DW'(f_q[mk]);
				end
			end
			default: begin
				mac_go = 1'b0;
			end
		endcase
	end

	assign mul_p  = mac_a * mac_b;
	assign acc_nx = mac_sub_s1 ? ((mac_clr_s1 ? '0 : acc_q) - prod_s1)
		: ((mac_clr_s1 ? '0 : acc_q) + prod_s1);
	assign out_load = !out_vld_q || rows.ready;

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		case (state_q)
			lavm_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = job.fwd_zero ? lavm_pkg::ST_EMIT : lavm_pkg::ST_SHIFT;
				end
			end
			lavm_pkg::ST_SHIFT: begin
				if (!too_big && !too_small) state_d = lavm_pkg::ST_SQ;
			end
			lavm_pkg::ST_SQ: begin
				if (cnt_q == N_SQ + 4'd1) state_d = lavm_pkg::ST_SQRT;
			end
			lavm_pkg::ST_SQRT: begin
				if (bit_q == lavm_pkg::AW'(1)) state_d = lavm_pkg::ST_DIVI;
			end
			lavm_pkg::ST_DIVI: begin
				state_d = lavm_pkg::ST_DIV;
			end
			lavm_pkg::ST_DIV: begin
				if (dcnt_q == '0) begin
					if (comp_q == 2'd2) begin
						state_d = pass_q ? lavm_pkg::ST_UP : lavm_pkg::ST_CROSS;
					end else begin
						state_d = lavm_pkg::ST_DIVI;
					end
				end
			end
			lavm_pkg::ST_CROSS: begin
				if (cnt_q == N_CROSS + 4'd1) begin
					state_d = lv_zero ? lavm_pkg::ST_EMIT : lavm_pkg::ST_SHIFT;
				end
			end
			lavm_pkg::ST_UP: begin
				if (cnt_q == N_UP + 4'd1) state_d = lavm_pkg::ST_UFIN;
			end
			lavm_pkg::ST_UFIN: begin
				state_d = lavm_pkg::ST_DOT;
			end
			lavm_pkg::ST_DOT: begin
				if (cnt_q == N_DOT + 4'd1) state_d = lavm_pkg::ST_TFIN;
			end
			lavm_pkg::ST_TFIN: begin
				state_d = lavm_pkg::ST_EMIT;
			end
			lavm_pkg::ST_EMIT: begin
				if (out_load && row_q == 2'd3) state_d = lavm_pkg::ST_IDLE;
			end
			default: begin
				state_d = lavm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lavm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row contents for the row now being emitted.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			em_col[i] = '0;
		end
		em_last = (row_q == 2'd3);
		if (degen_q) begin
			em_col[row_q] = lavm_pkg::ONE_FX;
		end else begin
			case (row_q)
				2'd0, 2'd1, 2'd2: begin
					em_col[0] = lavm_pkg::DW'(r_q[row_q]);
					em_col[1] = lavm_pkg::DW'(u_q[row_q]);
					em_col[2] = lavm_pkg::DW'(f_q[row_q]);
				end
				default: begin
					em_col[0] = t_q[0];
					em_col[1] = t_q[1];
					em_col[2] = t_q[2];
					em_col[3] = lavm_pkg::ONE_FX;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= (state_d != state_q) ? '0 : cnt_q + 4'd1;
		case (state_q)
			lavm_pkg::ST_IDLE: begin
				if (job_valid) begin
					for (int i = 0; i < 3; i++) begin
						eye_q[i] <= $signed(job.eye[i]);
						up_q[i]  <= $signed(job.up[i]);
						mag_q[i] <= lv_mag[i];
						neg_q[i] <= lv_neg[i];
					end
					pass_q  <= 1'b0;
					degen_q <= job.fwd_zero;
					row_q   <= 2'd0;
				end
			end
			lavm_pkg::ST_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					if (too_big) begin
						mag_q[i] <= mag_q[i] >> 1;
					end else if (too_small) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
			end
			lavm_pkg::ST_SQ: begin
				x_q    <= unsigned'(res_q[0]);
				sr_q   <= '0;
				bit_q  <= lavm_pkg::AW'(1) << (lavm_pkg::AW - 2);
				comp_q <= 2'd0;
			end
			lavm_pkg::ST_SQRT: begin
				if (sq_ge) begin
					x_q  <= x_q - sq_try;
					sr_q <= (sr_q >> 1) + bit_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			lavm_pkg::ST_DIVI: begin
				num_q  <= num_init[lavm_pkg::QW-1:0];
				rem_q  <= lavm_pkg::LW'(num_init[lavm_pkg::NUMW-1:lavm_pkg::QW]);
				quot_q <= '0;
				dcnt_q <= lavm_pkg::DCW'(lavm_pkg::QW - 1);
			end
			lavm_pkg::ST_DIV: begin
				rem_q  <= d_ge ? lavm_pkg::LW'(r2 - {1'b0, len}) : r2[lavm_pkg::LW-1:0];
				quot_q <= quot_nx;
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == '0) begin
					if (pass_q) begin
						r_q[comp_q] <= div_neg ? -q_signed : q_signed;
					end else begin
						f_q[comp_q] <= div_neg ? -q_signed : q_signed;
					end
					comp_q <= comp_q + 2'd1;
				end
			end
			lavm_pkg::ST_CROSS: begin
				if (cnt_q == N_CROSS + 4'd1) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= lv_mag[i];
						neg_q[i] <= lv_neg[i];
					end
					pass_q <= 1'b1;
					if (lv_zero) degen_q <= 1'b1;
				end
			end
			lavm_pkg::ST_UFIN: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i] <= lavm_pkg::UW'(lavm_pkg::shr_round(res_q[i]));
				end
			end
			lavm_pkg::ST_TFIN: begin
				for (int i = 0; i < 3; i++) begin
					t_q[i] <= lavm_pkg::sat32(-lavm_pkg::shr_round(res_q[i]));
				end
			end
			lavm_pkg::ST_EMIT: begin
				if (out_load) begin
					row_q       <= row_q + 2'd1;
					row_out_q   <= row_q;
					last_q      <= em_last;
					degen_out_q <= degen_q;
					for (int i = 0; i < 4; i++) begin
						col_q[i] <= em_col[i];
					end
				end
			end
			default: begin
				row_q <= row_q;
			end
		endcase

		prod_s1     <= mul_p;
		mac_clr_s1  <= mac_clr;
		mac_sub_s1  <= mac_sub;
		mac_last_s1 <= mac_last;
		mac_dst_s1  <= mac_dst;
		if (mac_vld_s1) begin
			acc_q <= acc_nx;
			if (mac_last_s1) res_q[mac_dst_s1] <= acc_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			mac_vld_s1 <= mac_go;
			if (state_q == lavm_pkg::ST_EMIT && out_load) begin
				out_vld_q <= 1'b1;
			end else if (rows.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rows.valid      = out_vld_q;
	assign rows.row_index  = row_out_q;
	assign rows.col_0      = col_q[0];
	assign rows.col_1      = col_q[1];
	assign rows.col_2      = col_q[2];
	assign rows.col_3      = col_q[3];
	assign rows.last_row   = last_q;
	assign rows.degenerate = degen_out_q;

	a_last_is_row3: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && last_q) |-> row_out_q == 2'd3)
		else $error("last row flag on a row other than the fourth");
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> state_q != lavm_pkg::ST_IDLE)
		else $error("job taken but sequencer stayed idle");
	a_mac_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mac_vld_s1 |-> (state_q == lavm_pkg::ST_SQ || state_q == lavm_pkg::ST_CROSS
			|| state_q == lavm_pkg::ST_UP || state_q == lavm_pkg::ST_DOT))
		else $error("product landed after its phase ended");
	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lavm_pkg::ST_SQRT |-> $onehot(bit_q))
		else $error("square root bit lost");
	a_degen_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && degen_out_q && row_out_q == 2'd0) |-> col_q[0] == lavm_pkg::ONE_FX)
		else $error("degenerate row 0 is not an identity row");

endmodule

>>> src/look_at_view_matrix.sv
// Top level of the left-handed look-at view matrix block.
// Depends on lavm_pkg, lavm_in_if, lavm_out_if, lavm_front and lavm_back.
//
// Usage: the pts channel carries one item per matrix: eye point, target point and
// an approximate up vector, all signed Q16.16. For each item the rows channel
// delivers four items, row_index 0 to 3 in order, last_row set on the fourth.
// Rows 0 to 2 hold (right, true up, forward, 0) by component; row 3 holds the
// negated dot products of right, true up and forward with the eye, then 1.0.
// If look equals eye, or up is zero or parallel to forward, the four rows form
// the identity matrix and degenerate is set on each of them.
// Timing: the front subtracts eye from target and queues up to two jobs, so the
// input side keeps accepting while the back end works. The back end runs on one
// multiplier, a one-bit-per-cycle square root (32 steps) and a one-bit-per-cycle
// divider (18 steps per component), used for forward and again for right.
// The time a full item takes from acceptance to the last row depends on the
// normalizing shift count; that iterative sqrt and divide sequence sets the
// sustained rate. A degenerate forward item skips straight to emitting rows.
// Reset clears the queue, the sequencer and the output valid; no item survives it.
// While the receiver stalls, the current row holds in the output register, the
// sequencer waits, and the queue fills before pts.ready drops.
module look_at_view_matrix (
	input  logic        clk,
	input  logic        arst_n,
	lavm_in_if.sink     pts,
	lavm_out_if.source  rows
);

	lavm_pkg::lavm_job_t job;
	logic                job_valid;
	logic                job_pop;

	lavm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pts       (pts),
		.job       (job),
		.job_valid (job_valid),
		.job_pop   (job_pop)
	);

	lavm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.rows      (rows)
	);

endmodule

>>> tb/sv/lavm_checker.sv
// Checker of the look-at view matrix block: watches the pts and rows channels.
// Depends on lavm_pkg, lavm_in_if and lavm_out_if; predicts rows and compares them.
module lavm_checker (
	input  logic clk,
	input  logic arst_n,
	lavm_in_if   pts,
	lavm_out_if  rows,
	output int   fail_count,
	output int   pending
);

	localparam int FB = lavm_pkg::FRAC_BITS;
	localparam longint ONE = longint'(1) << FB;

	typedef struct packed {
		logic [1:0]                     idx;
		logic signed [lavm_pkg::DW-1:0] c0;
		logic signed [lavm_pkg::DW-1:0] c1;
		logic signed [lavm_pkg::DW-1:0] c2;
		logic signed [lavm_pkg::DW-1:0] c3;
		logic                           last;
		logic                           degen;
	} mat_row_t;

	mat_row_t row_queue[$];

	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Scales to a largest magnitude in [2^29, 2^30), then divides by the length.
	function automatic bit unit_vec(input longint v[3], output longint r[3]);
		longint unsigned mag[3];
		bit neg[3];
		longint unsigned m, sum, len, q;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			mag[i] = neg[i] ? unsigned'(-v[i]) : unsigned'(v[i]);
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) return 0;
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		len = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << FB) + (len >> 1)) / len;
			r[i] = neg[i] ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint round_shift(input longint x);
		longint unsigned m;
		m = (x < 0) ? unsigned'(-x) : unsigned'(x);
		m = (m + (64'd1 << (FB - 1))) >> FB;
		return (x < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	task automatic predict_matrix();
		longint eye[3], look[3], up[3], d[3], f[3], c[3], r[3], u[3], t[3];
		bit ok;
		mat_row_t row;
		eye[0] = pts.eye_x;  eye[1] = pts.eye_y;  eye[2] = pts.eye_z;
		look[0] = pts.look_x; look[1] = pts.look_y; look[2] = pts.look_z;
		up[0] = pts.up_x;    up[1] = pts.up_y;    up[2] = pts.up_z;
		for (int i = 0; i < 3; i++) d[i] = look[i] - eye[i];
		ok = unit_vec(d, f);
		if (ok) begin
			c[0] = up[1] * f[2] - up[2] * f[1];
			c[1] = up[2] * f[0] - up[0] * f[2];
			c[2] = up[0] * f[1] - up[1] * f[0];
			ok = unit_vec(c, r);
		end
		if (!ok) begin
			// Degenerate basis: identity rows, flagged.
			for (int i = 0; i < 4; i++) begin
				row.idx = i[1:0];
				row.c0 = (i == 0) ? clamp32(ONE) : '0;
				row.c1 = (i == 1) ? clamp32(ONE) : '0;
				row.c2 = (i == 2) ? clamp32(ONE) : '0;
				row.c3 = (i == 3) ? clamp32(ONE) : '0;
				row.last = (i == 3);
				row.degen = 1'b1;
				row_queue.push_back(row);
			end
			return;
		end
		u[0] = round_shift(f[1] * r[2] - f[2] * r[1]);
		u[1] = round_shift(f[2] * r[0] - f[0] * r[2]);
		u[2] = round_shift(f[0] * r[1] - f[1] * r[0]);
		t[0] = -round_shift(r[0] * eye[0] + r[1] * eye[1] + r[2] * eye[2]);
		t[1] = -round_shift(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]);
		t[2] = -round_shift(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
		for (int i = 0; i < 3; i++) begin
			row.idx = i[1:0];
			row.c0 = clamp32(r[i]);
			row.c1 = clamp32(u[i]);
			row.c2 = clamp32(f[i]);
			row.c3 = '0;
			row.last = 1'b0;
			row.degen = 1'b0;
			row_queue.push_back(row);
		end
		row.idx = 2'd3;
		row.c0 = clamp32(t[0]);
		row.c1 = clamp32(t[1]);
		row.c2 = clamp32(t[2]);
		row.c3 = clamp32(ONE);
		row.last = 1'b1;
		row.degen = 1'b0;
		row_queue.push_back(row);
	endtask

	function automatic int field_diff(input string name, input longint exp_v,
		input longint act_v);
		if (exp_v == act_v) return 0;
		$display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
		return 1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		mat_row_t want;
		int bad;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			row_queue.delete();
		end else begin
			bad = 0;
			if (pts.valid && pts.ready) begin
				predict_matrix();
			end
			if (rows.valid && rows.ready) begin
				if (row_queue.size() == 0) begin
					$display("%0t: row item with none expected, row_index %0d",
						$time, rows.row_index);
					bad = 1;
				end else begin
					want = row_queue.pop_front();
					bad += field_diff("row_index", want.idx, rows.row_index);
					bad += field_diff("col_0", want.c0, rows.col_0);
					bad += field_diff("col_1", want.c1, rows.col_1);
					bad += field_diff("col_2", want.c2, rows.col_2);
					bad += field_diff("col_3", want.c3, rows.col_3);
					bad += field_diff("last_row", want.last, rows.last_row);
					bad += field_diff("degenerate", want.degen, rows.degenerate);
				end
			end
			if (bad != 0) fail_count <= fail_count + 1;
			pending <= row_queue.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
// Top of the look-at view matrix testbench: clock, reset, stimulus and verdict.
// Depends on lavm_pkg, both channel interfaces, the block and lavm_checker.
module tb;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	// Set by the sender to ask the receiver for one long hold-off.
	bit   hold_req;

	lavm_in_if  pts();
	lavm_out_if rows();

	look_at_view_matrix u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts),
		.rows   (rows)
	);

	lavm_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pts        (pts),
		.rows       (rows),
		.fail_count (fail_count),
		.pending    (pending)
	);

	typedef logic signed [31:0] coord_t;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hard stop, far beyond the slowest correct run.
	initial begin
		#40000000;
		$display("look_at_view_matrix regression: fail");
		$finish;
	end

	// Offers one item and holds it until the block takes it. The caller is
	// just past a rising edge; ready is sampled at the falling edge, where it
	// is settled, and the item is taken at the rising edge that follows.
	task automatic offer(input coord_t ex, ey, ez, lx, ly, lz, ux, uy, uz);
		bit took;
		pts.eye_x <= ex;  pts.eye_y <= ey;  pts.eye_z <= ez;
		pts.look_x <= lx; pts.look_y <= ly; pts.look_z <= lz;
		pts.up_x <= ux;   pts.up_y <= uy;   pts.up_z <= uz;
		pts.valid <= 1'b1;
		do begin
			@(negedge clk);
			took = pts.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Random gap after an item: usually none, mostly short, a few long.
	task automatic sender_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = 0;
		if (r >= 65 && r < 92) n = $urandom_range(1, 3);
		else if (r >= 92) n = $urandom_range(20, 90);
		if (n > 0) begin
			pts.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Coordinate mix: full-range values exercise every bit, small and
	// medium ones keep most matrices free of saturation.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0, 1: return coord_t'($urandom);
			2: return 32'sh80000000;
			3: return 32'sh7fffffff;
			4, 5: return coord_t'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
			default: return coord_t'(int'($urandom_range(0, 2000 << 16)) - (1000 << 16));
		endcase
	endfunction

	initial begin
		coord_t ex, ey, ez, lx, ly, lz, ux, uy, uz;
		int k;
		arst_n <= 1'b0;
		hold_req = 1'b0;
		pts.valid <= 1'b0;
		pts.eye_x <= '0;  pts.eye_y <= '0;  pts.eye_z <= '0;
		pts.look_x <= '0; pts.look_y <= '0; pts.look_z <= '0;
		pts.up_x <= '0;   pts.up_y <= '0;   pts.up_z <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed part. A plain camera looking down +z with y up.
		offer(0, 0, 0, 0, 0, 1 << 16, 0, 1 << 16, 0);
		// Target equal to the eye: zero-length forward.
		offer(5 << 16, -3 << 16, 7, 5 << 16, -3 << 16, 7, 0, 1 << 16, 0);
		// Up vector of zero length.
		offer(1 << 16, 2 << 16, 3 << 16, 4 << 16, 2 << 16, 3 << 16, 0, 0, 0);
		// Up parallel to forward: zero-length right.
		offer(0, 0, 0, 0, 0, 5 << 16, 0, 0, 2 << 16);
		// Anti-parallel up, also degenerate.
		offer(0, 0, 0, 3 << 16, 0, 0, -7 << 16, 0, 0);
		// Full-span direction, eye at the negative extreme.
		offer(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 1 << 16, 0);
		// The opposite span with extreme up components.
		offer(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		// Eye at the positive extreme looking back to the origin: the
		// translation row overflows and saturates.
		offer(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0, 1 << 16, 0);
		offer(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 1 << 16, 0, 0);
		// Smallest possible direction, one LSB.
		offer(0, 0, 0, 1, 0, 0, 0, 0, 1);
		// Negative components everywhere.
		offer(-9 << 16, -4 << 16, -1, -2 << 16, -8 << 16, -6 << 16,
			-1 << 16, -3, -5 << 16);
		// Up vector at full scale with a short direction.
		offer(100, -200, 300, 101, -199, 302, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
		// All-ones pattern versus alternating bits.
		offer(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa,
			32'sh55555555, 32'shaaaaaaaa, 32'shffffffff,
			32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh00ff00ff);
		sender_gap();

		for (k = 0; k < 200; k++) begin
			ex = pick_coord(); ey = pick_coord(); ez = pick_coord();
			lx = pick_coord(); ly = pick_coord(); lz = pick_coord();
			ux = pick_coord(); uy = pick_coord(); uz = pick_coord();
			case ($urandom_range(0, 19))
				0: begin
					lx = ex; ly = ey; lz = ez;
				end
				1: begin
					// Direction and up both along one axis.
					ex = coord_t'(int'($urandom_range(0, 200 << 16)) - (100 << 16));
					lx = ex + coord_t'($urandom_range(1, 50 << 16));
					ly = ey; lz = ez;
					ux = coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
					uy = 0; uz = 0;
				end
				default: ;
			endcase
			if (k == 60) hold_req = 1'b1;
			offer(ex, ey, ez, lx, ly, lz, ux, uy, uz);
			if (k == 120) begin
				// Let the block drain completely before going on.
				pts.valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
				@(posedge clk);
			end else begin
				sender_gap();
			end
		end
		pts.valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (400) @(posedge clk);
		if (fail_count == 0) begin
			$display("look_at_view_matrix regression: pass");
		end else begin
			$display("look_at_view_matrix regression: fail");
		end
		$finish;
	end

	// Receiver: random stalls on the row channel, plus one long hold-off
	// while the sender keeps offering, so the job queue fills and pts stalls.
	initial begin
		int r;
		int n;
		rows.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_req) begin
				rows.ready <= 1'b0;
				n = 3000;
				hold_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					rows.ready <= 1'b1;
					n = 1;
				end else if (r < 82) begin
					rows.ready <= 1'b0;
					n = $urandom_range(1, 3);
				end else if (r < 88) begin
					rows.ready <= 1'b0;
					n = $urandom_range(20, 70);
				end else begin
					rows.ready <= 1'b1;
					n = $urandom_range(50, 200);
				end
			end
			repeat (n) @(posedge clk);
		end
	end

endmodule
